FILE: rtl/assert_macros.svh
// assertion macros shared by the servo pulse generator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk_i) prop) \
  else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/msp_pkg.sv
// types and constants of the servo pulse generator
package msp_pkg;

  localparam int unsigned WIDTH_W = 16;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned PIN_W   = 4;
  localparam int unsigned CFG_W   = 2;

  localparam logic [WIDTH_W-1:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [WIDTH_W-1:0] MIN_RST     = 16'd500;
  localparam logic [WIDTH_W-1:0] MAX_RST     = 16'd2500;
  localparam logic [WIDTH_W-1:0] DEFAULT_RST = 16'd1500;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_START   = 3'd1,
    OP_SET     = 3'd2,
    OP_GET     = 3'd3,
    OP_SET_ALL = 3'd4,
    OP_ENABLE  = 3'd5,
    OP_DISABLE = 3'd6,
    OP_INIT    = 3'd7
  } op_e;

  typedef enum logic [CFG_W-1:0] {
    CFG_MIN     = 2'd0,
    CFG_MAX     = 2'd1,
    CFG_DEFAULT = 2'd2
  } cfg_e;

  typedef struct packed {
    op_e                op;
    logic [CH_W-1:0]    channel;
    logic [WIDTH_W-1:0] pulse_width;
  } item_t;

  typedef struct packed {
    logic [PIN_W-1:0]   pin_levels;
    logic [WIDTH_W-1:0] read_width;
    logic               frame_running;
  } result_t;

endpackage

FILE: rtl/msp_core.sv
// channel state, configuration registers and per-item update logic
`include "assert_macros.svh"

module msp_core #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [msp_pkg::CFG_W-1:0]     cfg_index_i,
  input  logic [msp_pkg::WIDTH_W-1:0]   cfg_data_i,
  input  logic                          fire_i,
  input  msp_pkg::item_t                item_i,
  output msp_pkg::result_t              result_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PinN = (CHANNELS < msp_pkg::PIN_W) ? CHANNELS : msp_pkg::PIN_W;

  logic [msp_pkg::WIDTH_W-1:0] min_q, max_q, default_q;
  logic [msp_pkg::WIDTH_W-1:0] width_q [CHANNELS];
  logic [msp_pkg::WIDTH_W-1:0] width_d [CHANNELS];
  logic [msp_pkg::WIDTH_W-1:0] frame_q [CHANNELS];
  logic [msp_pkg::WIDTH_W-1:0] frame_d [CHANNELS];
  logic [msp_pkg::WIDTH_W-1:0] elapsed_q, elapsed_d;
  logic [CHANNELS-1:0]         high_q, high_d;
  logic                        enabled_q, enabled_d;
  logic [msp_pkg::WIDTH_W-1:0] clamped;
  logic [msp_pkg::WIDTH_W-1:0] read_width;
  logic                        ch_valid;
  logic [IdxW-1:0]             ch_idx;
  logic [CHANNELS-1:0]         zero_mask;

  // raise to min first, then lower to max
  always_comb begin
    clamped = item_i.pulse_width;
    if (clamped < min_q) begin
      clamped = min_q;
    end
    if (clamped > max_q) begin
      clamped = max_q;
    end
  end

  assign ch_valid = item_i.channel < msp_pkg::CH_W'(CHANNELS);
  assign ch_idx   = item_i.channel[IdxW-1:0];

  always_comb begin
    width_d    = width_q;
    frame_d    = frame_q;
    elapsed_d  = elapsed_q;
    high_d     = high_q;
    enabled_d  = enabled_q;
    read_width = '0;
    case (item_i.op)
      msp_pkg::OP_TICK: begin
        if (elapsed_q != msp_pkg::COUNT_MAX) begin
          elapsed_d = elapsed_q + msp_pkg::WIDTH_W'(1);
        end
        for (int i = 0; i < CHANNELS; i++) begin
          if (frame_q[i] <= elapsed_d) begin
            high_d[i] = 1'b0;
          end
        end
      end
      msp_pkg::OP_START: begin
        if (enabled_q) begin
          elapsed_d = '0;
          for (int i = 0; i < CHANNELS; i++) begin
            frame_d[i] = width_q[i];
            high_d[i]  = width_q[i] != '0;
          end
        end
      end
      msp_pkg::OP_SET: begin
        if (ch_valid) begin
          width_d[ch_idx] = clamped;
        end
      end
      msp_pkg::OP_GET: begin
        read_width = ch_valid ? width_q[ch_idx] : default_q;
      end
      msp_pkg::OP_SET_ALL: begin
        for (int i = 0; i < CHANNELS; i++) begin
          width_d[i] = clamped;
        end
        if (enabled_q) begin
          elapsed_d = '0;
          for (int i = 0; i < CHANNELS; i++) begin
            frame_d[i] = clamped;
            high_d[i]  = clamped != '0;
          end
        end
      end
      msp_pkg::OP_ENABLE: begin
        enabled_d = 1'b1;
      end
      msp_pkg::OP_DISABLE: begin
        enabled_d = 1'b0;
        high_d    = '0;
        elapsed_d = '0;
      end
      msp_pkg::OP_INIT: begin
        for (int i = 0; i < CHANNELS; i++) begin
          width_d[i] = default_q;
        end
        high_d    = '0;
        elapsed_d = '0;
        enabled_d = 1'b1;
      end
      default: begin
        read_width = '0;
      end
    endcase
  end

  always_comb begin
    result_o                       = '0;
    result_o.pin_levels[PinN-1:0]  = high_d[PinN-1:0];
    result_o.read_width            = read_width;
    result_o.frame_running         = |high_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= msp_pkg::MIN_RST;
      max_q     <= msp_pkg::MAX_RST;
      default_q <= msp_pkg::DEFAULT_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        width_q[i] <= msp_pkg::DEFAULT_RST;
        frame_q[i] <= '0;
      end
      elapsed_q <= '0;
      high_q    <= '0;
      enabled_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          msp_pkg::CFG_MIN:     min_q     <= cfg_data_i;
          msp_pkg::CFG_MAX:     max_q     <= cfg_data_i;
          msp_pkg::CFG_DEFAULT: default_q <= cfg_data_i;
          default: begin
            min_q <= min_q;
          end
        endcase
      end
      if (fire_i) begin
        width_q   <= width_d;
        frame_q   <= frame_d;
        elapsed_q <= elapsed_d;
        high_q    <= high_d;
        enabled_q <= enabled_d;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      zero_mask[i] = frame_q[i] == '0;
    end
  end

  `ASSERT_CLK(a_high_needs_enable, (high_q != '0) |-> enabled_q)
  `ASSERT_CLK(a_high_needs_width, (high_q & zero_mask) == '0)
  `ASSERT_CLK(a_disable_clears, fire_i && item_i.op == msp_pkg::OP_DISABLE |=> high_q == '0 && !enabled_q && elapsed_q == '0)

endmodule

FILE: rtl/multi_channel_servo_pulse_generator_top.sv
// top level of the servo pulse generator: input register, core and result register
//
// channel  direction  handshake                    payload
// in       in         in_valid_i / in_stall_o      operation_i, channel_i, pulse_width_i
// out      out        out_valid_o / out_stall_i    pin_levels_o, read_width_o, frame_running_o
// cfg      in         cfg_we_i                     cfg_index_i, cfg_data_i
//
// one item per cycle when not stalled; result registered after the input register
// the state update and result come from one pass through the core logic
// asynchronous active-low reset clears control state and sets the channel widths to default
// a stalled result holds in the output register; the input register still takes one item

`include "assert_macros.svh"

module multi_channel_servo_pulse_generator_top #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [msp_pkg::CFG_W-1:0]     cfg_index_i,
  input  logic [msp_pkg::WIDTH_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    operation_i,
  input  logic [msp_pkg::CH_W-1:0]      channel_i,
  input  logic [msp_pkg::WIDTH_W-1:0]   pulse_width_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [msp_pkg::PIN_W-1:0]     pin_levels_o,
  output logic [msp_pkg::WIDTH_W-1:0]   read_width_o,
  output logic                          frame_running_o
);

  logic             in_vld_q;
  msp_pkg::item_t   item_q;
  logic             out_vld_q;
  msp_pkg::result_t res_q;
  msp_pkg::result_t res_d;
  logic             adv;
  logic             fire;
  logic             in_xfer;

  assign adv        = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.op          <= msp_pkg::op_e'(operation_i);
      item_q.channel     <= channel_i;
      item_q.pulse_width <= pulse_width_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  msp_core #(
    .CHANNELS(CHANNELS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (item_q),
    .result_o   (res_d)
  );

  assign out_valid_o     = out_vld_q;
  assign pin_levels_o    = res_q.pin_levels;
  assign read_width_o    = res_q.read_width;
  assign frame_running_o = res_q.frame_running;

  `ASSERT_CLK(a_stall_only_when_full, in_stall_o |-> in_vld_q && out_vld_q)
  `ASSERT_CLK(a_fire_fills_out, fire |=> out_vld_q)
  `ASSERT_CLK(a_idle_pins_low, out_valid_o && !frame_running_o |-> pin_levels_o == '0)

endmodule
